[src/cdsd_pkg.sv]
// ----------------------------------------------------------------------------
// cdsd_pkg
// Shared types, constants and the segment table of the countdown display.
// ----------------------------------------------------------------------------
package cdsd_pkg;

  localparam int NumDigits   = 4;
  localparam int ShownDepth  = 4;
  localparam int ScanW       = (NumDigits > 1) ? $clog2(NumDigits) : 1;
  localparam int CountW      = 14;
  localparam int FillW       = 3;
  localparam int SegW        = 8;
  localparam int EnW         = 4;
  localparam int CmdW        = 3;
  localparam int CharW       = 8;

  localparam logic [CountW-1:0] WrapValue   = CountW'(9999);
  localparam logic [CountW-1:0] PresetValue = CountW'(10000);
  localparam logic [FillW-1:0]  EntryCap    = FillW'(4);
  localparam logic [SegW-1:0]   SegBlank    = 8'hFF;
  localparam logic [CharW-1:0]  CharZero    = 8'h30;
  localparam logic [CharW-1:0]  CharNine    = 8'h39;

  typedef enum logic [CmdW-1:0] {
    CmdCount  = 3'd0,
    CmdScan   = 3'd1,
    CmdChar   = 3'd2,
    CmdCommit = 3'd3,
    CmdPreset = 3'd4
  } cmd_e;

  typedef logic [3:0] digit_t;
  typedef digit_t [ShownDepth-1:0] bcd_t;

  typedef struct packed {
    logic [SegW-1:0]   segment_pattern;
    logic [EnW-1:0]    digit_enable;
    logic [CountW-1:0] count_value;
    logic [FillW-1:0]  entry_fill;
  } res_t;

  function automatic logic [SegW-1:0] seg_decode(digit_t d);
    logic [SegW-1:0] s;
    unique case (d)
      4'd0:    s = 8'hC0;
      4'd1:    s = 8'hF9;
      4'd2:    s = 8'hA4;
      4'd3:    s = 8'hB0;
      4'd4:    s = 8'h99;
      4'd5:    s = 8'h92;
      4'd6:    s = 8'h82;
      4'd7:    s = 8'hF8;
      4'd8:    s = 8'h80;
      4'd9:    s = 8'h90;
      default: s = SegBlank;
    endcase
    return s;
  endfunction

  function automatic logic [CountW-1:0] bcd_to_bin(bcd_t b);
    logic [CountW-1:0] v;
    v = CountW'(b[3]) * CountW'(1000) + CountW'(b[2]) * CountW'(100)
      + CountW'(b[1]) * CountW'(10) + CountW'(b[0]);
    return v;
  endfunction

endpackage

[src/cdsd_req_if.sv]
// ----------------------------------------------------------------------------
// cdsd_req_if
// Request channel: event command and received character.
// ----------------------------------------------------------------------------
interface cdsd_req_if
  import cdsd_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CmdW-1:0]  command;
  logic [CharW-1:0] rx_char;

  modport source (output valid, output command, output rx_char, input ready);
  modport sink   (input valid, input command, input rx_char, output ready);
endinterface

[src/cdsd_res_if.sv]
// ----------------------------------------------------------------------------
// cdsd_res_if
// Result channel: display drive, count and entry fill after each request.
// ----------------------------------------------------------------------------
interface cdsd_res_if
  import cdsd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [SegW-1:0]   segment_pattern;
  logic [EnW-1:0]    digit_enable;
  logic [CountW-1:0] count_value;
  logic [FillW-1:0]  entry_fill;

  modport source (output valid, output segment_pattern, output digit_enable,
                  output count_value, output entry_fill, input ready);
  modport sink   (input valid, input segment_pattern, input digit_enable,
                  input count_value, input entry_fill, output ready);
endinterface

[src/cdsd_bcd_dec.sv]
// ----------------------------------------------------------------------------
// cdsd_bcd_dec
// Four-digit BCD decrement, wrapping from 0000 to 9999.
// ----------------------------------------------------------------------------
module cdsd_bcd_dec
  import cdsd_pkg::*;
(
  input  bcd_t val_i,
  output bcd_t val_o
);

  always_comb begin
    logic borrow;
    borrow = 1'b1;
    for (int k = 0; k < ShownDepth; k++) begin
      if (!borrow) begin
        val_o[k] = val_i[k];
      end else if (val_i[k] == 4'd0) begin
        val_o[k] = 4'd9;
      end else begin
        val_o[k] = val_i[k] - 4'd1;
        borrow   = 1'b0;
      end
    end
  end

endmodule

[src/countdown_seven_segment_display.sv]
// ----------------------------------------------------------------------------
// countdown_seven_segment_display
// Four-digit countdown with multiplexed seven-segment drive and serial entry.
// Timing: result registered, valid in the cycle after the request is accepted.
// Throughput: one request per cycle; ready stays high while the result
//   register is empty or being taken.
// Reset: count, shown digits, scan position and entry fill clear to zero,
//   segments all off (0xFF), no digit enabled, result register empty.
// ----------------------------------------------------------------------------
module countdown_seven_segment_display
  import cdsd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  cdsd_req_if.sink   req_i,
  cdsd_res_if.source res_o
);

  logic [CountW-1:0] count_q, count_d;
  bcd_t              bcd_q, bcd_d;
  bcd_t              shown_q, shown_d;
  logic [ScanW-1:0]  scan_q, scan_d;
  bcd_t              entry_q, entry_d;
  logic [FillW-1:0]  fill_q, fill_d;
  logic [SegW-1:0]   seg_q, seg_d;
  logic [EnW-1:0]    en_q, en_d;
  logic              res_valid_q;
  res_t              res_q;

  bcd_t              bcd_dec;
  bcd_t              entry_bcd;
  logic [1:0]        scan_idx;
  logic              accept;
  logic              is_digit;

  cdsd_bcd_dec u_dec (
    .val_i (bcd_q),
    .val_o (bcd_dec)
  );

  assign req_i.ready = !res_valid_q || res_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign scan_idx    = 2'(scan_q);
  assign is_digit    = (req_i.rx_char >= CharZero) && (req_i.rx_char <= CharNine);

  // buffered digits, newest in the units place
  always_comb begin
    for (int k = 0; k < ShownDepth; k++) begin
      entry_bcd[k] = (FillW'(k) < fill_q) ? entry_q[k] : 4'd0;
    end
  end

  always_comb begin
    count_d = count_q;
    bcd_d   = bcd_q;
    shown_d = shown_q;
    scan_d  = scan_q;
    entry_d = entry_q;
    fill_d  = fill_q;
    seg_d   = seg_q;
    en_d    = en_q;
    case (req_i.command)
      CmdCount: begin
        count_d = (count_q == '0) ? WrapValue : count_q - CountW'(1);
        bcd_d   = bcd_dec;
        shown_d = bcd_dec;
      end
      CmdScan: begin
        if (int'(scan_q) < ShownDepth) begin
          seg_d = seg_decode(shown_q[scan_idx]);
          en_d  = EnW'(1) << scan_idx;
        end else begin
          seg_d = SegBlank;
          en_d  = '0;
        end
        scan_d = (int'(scan_q) == NumDigits - 1) ? '0 : scan_q + ScanW'(1);
      end
      CmdChar: begin
        if (is_digit && fill_q < EntryCap) begin
          for (int k = ShownDepth - 1; k > 0; k--) begin
            entry_d[k] = entry_q[k-1];
          end
          entry_d[0] = req_i.rx_char[3:0];
          fill_d     = fill_q + FillW'(1);
        end
      end
      CmdCommit: begin
        if (fill_q != '0) begin
          count_d = bcd_to_bin(entry_bcd);
          bcd_d   = entry_bcd;
          shown_d = entry_bcd;
          fill_d  = '0;
        end
      end
      CmdPreset: begin
        count_d = PresetValue;
        bcd_d   = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      bcd_q   <= '0;
      shown_q <= '0;
      scan_q  <= '0;
      fill_q  <= '0;
      seg_q   <= SegBlank;
      en_q    <= '0;
    end else if (accept) begin
      count_q <= count_d;
      bcd_q   <= bcd_d;
      shown_q <= shown_d;
      scan_q  <= scan_d;
      fill_q  <= fill_d;
      seg_q   <= seg_d;
      en_q    <= en_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      entry_q <= entry_d;
      res_q   <= '{segment_pattern: seg_d, digit_enable: en_d,
                   count_value: count_d, entry_fill: fill_d};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (accept) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  assign res_o.valid           = res_valid_q;
  assign res_o.segment_pattern = res_q.segment_pattern;
  assign res_o.digit_enable    = res_q.digit_enable;
  assign res_o.count_value     = res_q.count_value;
  assign res_o.entry_fill      = res_q.entry_fill;

endmodule

[src/cdsd_checker.sv]
// ----------------------------------------------------------------------------
// cdsd_checker
// Port-level checks of the countdown display, bound to the top level.
// ----------------------------------------------------------------------------
module cdsd_checker
  import cdsd_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_ready,
  input logic              res_valid,
  input logic              res_ready,
  input logic [EnW-1:0]    res_enable,
  input logic [CountW-1:0] res_count,
  input logic [FillW-1:0]  res_fill
);

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_valid |-> req_ready)
    else $error("request not taken while result register empty");

  a_enable_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> $onehot0(res_enable))
    else $error("digit enable not one-hot");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> res_count <= PresetValue)
    else $error("count out of range");

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> res_fill <= EntryCap)
    else $error("entry fill out of range");

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res_count))
    else $error("stalled result dropped or changed");

endmodule

bind countdown_seven_segment_display cdsd_checker u_cdsd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .req_ready  (req_i.ready),
  .res_valid  (res_o.valid),
  .res_ready  (res_o.ready),
  .res_enable (res_o.digit_enable),
  .res_count  (res_o.count_value),
  .res_fill   (res_o.entry_fill)
);
